FILE: rtl/slbb_pkg.sv
// Shared types, codes and reset values for the status LED blink and breathe controller.
package slbb_pkg;

    localparam int unsigned LEVEL_W   = 8;
    localparam int unsigned STATE_W   = 3;
    localparam int unsigned COUNT_W   = 6;
    localparam int unsigned RF_W      = 2;
    localparam int unsigned S_TDATA_W = 8;
    localparam int unsigned M_TDATA_W = 80;
    localparam int unsigned PAD_W     = M_TDATA_W - 9 * LEVEL_W - RF_W;
    localparam int unsigned APB_AW    = 4;
    localparam int unsigned APB_DW    = 32;

    localparam logic [COUNT_W-1:0] BLINK_TICKS_RST = 6'd20;
    localparam logic [COUNT_W-1:0] HOLD_TICKS_RST  = 6'd40;
    localparam logic [LEVEL_W-1:0] RAMP_STEP_RST   = 8'd50;
    localparam logic [LEVEL_W-1:0] RAMP_PEAK_RST   = 8'd250;

    localparam logic [LEVEL_W-1:0] LEVEL_FULL   = 8'hFF;
    localparam logic [LEVEL_W-1:0] LEVEL_ORANGE = 8'h5E;
    localparam logic [LEVEL_W-1:0] LEVEL_DARK   = 8'h00;

    typedef enum logic [STATE_W-1:0] {
        COL_BLUE   = 3'd0,
        COL_GREEN  = 3'd1,
        COL_YELLOW = 3'd2,
        COL_ORANGE = 3'd3,
        COL_RED    = 3'd4,
        COL_OFF    = 3'd5
    } color_t;

    localparam logic [STATE_W-1:0] ST_READY = 3'd1;
    localparam logic [STATE_W-1:0] ST_ON    = 3'd2;
    localparam logic [STATE_W-1:0] ST_LAST  = 3'd4;

    typedef enum logic [RF_W-1:0] {
        RF_NONE = 2'd0,
        RF_ON   = 2'd1,
        RF_OFF  = 2'd2
    } rf_action_t;

    typedef enum logic [1:0] {
        REG_BLINK_TICKS = 2'd0,
        REG_HOLD_TICKS  = 2'd1,
        REG_RAMP_STEP   = 2'd2,
        REG_RAMP_PEAK   = 2'd3
    } reg_index_t;

    typedef struct packed {
        logic [COUNT_W-1:0] blink_ticks;
        logic [COUNT_W-1:0] hold_ticks;
        logic [LEVEL_W-1:0] ramp_step;
        logic [LEVEL_W-1:0] ramp_peak;
    } cfg_t;

    // Packed with the last declared field, left_red, in the lowest bits of tdata.
    typedef struct packed {
        logic [PAD_W-1:0]   pad;
        logic [RF_W-1:0]    rf_switch_led;
        logic [LEVEL_W-1:0] right_blue;
        logic [LEVEL_W-1:0] right_green;
        logic [LEVEL_W-1:0] right_red;
        logic [LEVEL_W-1:0] mid_blue;
        logic [LEVEL_W-1:0] mid_green;
        logic [LEVEL_W-1:0] mid_red;
        logic [LEVEL_W-1:0] left_blue;
        logic [LEVEL_W-1:0] left_green;
        logic [LEVEL_W-1:0] left_red;
    } result_t;

endpackage

FILE: rtl/slbb_cfg.sv
// APB register file holding the blink, hold and breathing ramp settings.
module slbb_cfg (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [slbb_pkg::APB_AW-1:0]  paddr,
    input  logic [slbb_pkg::APB_DW-1:0]  pwdata,
    output logic [slbb_pkg::APB_DW-1:0]  prdata,
    output logic                         pready,
    output slbb_pkg::cfg_t               cfg
);
    import slbb_pkg::*;

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    reg_index_t index;
    logic       wr_en;

    assign index  = reg_index_t'(paddr[3:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (index)
                REG_BLINK_TICKS: cfg_next.blink_ticks = pwdata[COUNT_W-1:0];
                REG_HOLD_TICKS:  cfg_next.hold_ticks  = pwdata[COUNT_W-1:0];
                REG_RAMP_STEP:   cfg_next.ramp_step   = pwdata[LEVEL_W-1:0];
                REG_RAMP_PEAK:   cfg_next.ramp_peak   = pwdata[LEVEL_W-1:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb begin
        unique case (index)
            REG_BLINK_TICKS: prdata = {{(APB_DW-COUNT_W){1'b0}}, cfg_reg.blink_ticks};
            REG_HOLD_TICKS:  prdata = {{(APB_DW-COUNT_W){1'b0}}, cfg_reg.hold_ticks};
            REG_RAMP_STEP:   prdata = {{(APB_DW-LEVEL_W){1'b0}}, cfg_reg.ramp_step};
            REG_RAMP_PEAK:   prdata = {{(APB_DW-LEVEL_W){1'b0}}, cfg_reg.ramp_peak};
            default:         prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.blink_ticks <= BLINK_TICKS_RST;
            cfg_reg.hold_ticks  <= HOLD_TICKS_RST;
            cfg_reg.ramp_step   <= RAMP_STEP_RST;
            cfg_reg.ramp_peak   <= RAMP_PEAK_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

FILE: rtl/slbb_core.sv
// Color, blink counter and breathing ramp state with the per-tick LED level logic.
module slbb_core (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          tick,
    input  logic [slbb_pkg::STATE_W-1:0]  system_state,
    input  slbb_pkg::cfg_t                cfg,
    output slbb_pkg::result_t             result
);
    import slbb_pkg::*;

    color_t             shown_color_reg;
    color_t             shown_color_next;
    logic               lit_reg;
    logic               lit_next;
    logic [COUNT_W-1:0] blink_count_reg;
    logic [COUNT_W-1:0] blink_count_next;
    logic               ramp_rising_reg;
    logic               ramp_rising_next;
    logic [LEVEL_W-1:0] ramp_level_reg;
    logic [LEVEL_W-1:0] ramp_level_next;

    logic [LEVEL_W-1:0] mid_level;
    logic [LEVEL_W:0]   ramp_sum;
    logic [COUNT_W-1:0] count_inc;

    assign shown_color_next = (system_state <= ST_LAST) ? color_t'(system_state)
                                                        : shown_color_reg;
    assign mid_level = (ramp_level_reg > cfg.ramp_peak) ? LEVEL_DARK
                                                        : cfg.ramp_peak - ramp_level_reg;

    always_comb begin
        result = '0;
        unique case (shown_color_next)
            COL_YELLOW: begin
                if (lit_reg) begin
                    result.left_red    = ramp_level_reg;
                    result.left_green  = ramp_level_reg;
                    result.mid_red     = mid_level;
                    result.mid_green   = mid_level;
                    result.right_red   = ramp_level_reg;
                    result.right_green = ramp_level_reg;
                end
            end
            COL_ORANGE: begin
                result.mid_red   = LEVEL_FULL;
                result.mid_green = LEVEL_ORANGE;
            end
            COL_RED: begin
                result.mid_red = LEVEL_FULL;
            end
            default: begin
                if (lit_reg) begin
                    if (shown_color_next == COL_BLUE) begin
                        result.mid_blue = LEVEL_FULL;
                    end
                    if (shown_color_next == COL_GREEN) begin
                        result.mid_green = LEVEL_FULL;
                    end
                    if (system_state == ST_READY || system_state == ST_ON) begin
                        result.rf_switch_led = RF_ON;
                    end
                end else begin
                    result.rf_switch_led = RF_OFF;
                end
            end
        endcase
    end

    // The ramp saturates at full scale and at zero, and turns at or above the peak or at zero.
    always_comb begin
        ramp_sum = {1'b0, ramp_level_reg} + {1'b0, cfg.ramp_step};
        if (ramp_rising_reg) begin
            ramp_level_next = ramp_sum[LEVEL_W] ? LEVEL_FULL : ramp_sum[LEVEL_W-1:0];
        end else begin
            ramp_level_next = (ramp_level_reg > cfg.ramp_step)
                            ? ramp_level_reg - cfg.ramp_step : LEVEL_DARK;
        end
        if (ramp_level_next >= cfg.ramp_peak) begin
            ramp_rising_next = 1'b0;
        end else if (ramp_level_next == LEVEL_DARK) begin
            ramp_rising_next = 1'b1;
        end else begin
            ramp_rising_next = ramp_rising_reg;
        end
    end

    always_comb begin
        count_inc        = blink_count_reg + COUNT_W'(1);
        blink_count_next = count_inc;
        lit_next         = lit_reg;
        if (shown_color_next != COL_YELLOW && count_inc >= cfg.blink_ticks) begin
            lit_next         = !lit_reg;
            blink_count_next = '0;
        end else if (shown_color_next == COL_YELLOW && count_inc >= cfg.hold_ticks) begin
            lit_next         = 1'b0;
            blink_count_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            shown_color_reg <= COL_OFF;
            lit_reg         <= 1'b1;
            blink_count_reg <= '0;
            ramp_rising_reg <= 1'b1;
            ramp_level_reg  <= '0;
        end else if (tick) begin
            shown_color_reg <= shown_color_next;
            lit_reg         <= lit_next;
            blink_count_reg <= blink_count_next;
            ramp_rising_reg <= ramp_rising_next;
            ramp_level_reg  <= ramp_level_next;
        end
    end

endmodule

FILE: rtl/slbb_out_buf.sv
// Two-entry result register with a skid stage so that the request ready is registered.
module slbb_out_buf (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  slbb_pkg::result_t              in_data,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [slbb_pkg::M_TDATA_W-1:0] m_tdata
);
    import slbb_pkg::*;

    result_t main_reg;
    result_t main_next;
    logic    main_valid_reg;
    logic    main_valid_next;
    result_t skid_reg;
    result_t skid_next;
    logic    skid_valid_reg;
    logic    skid_valid_next;
    logic    in_fire;
    logic    out_fire;

    assign in_ready = !skid_valid_reg;
    assign in_fire  = in_valid && in_ready;
    assign out_fire = main_valid_reg && m_tready;
    assign m_tvalid = main_valid_reg;
    assign m_tdata  = main_reg;

    always_comb begin
        main_next       = main_reg;
        main_valid_next = main_valid_reg;
        skid_next       = skid_reg;
        skid_valid_next = skid_valid_reg;
        if (skid_valid_reg) begin
            if (out_fire) begin
                main_next       = skid_reg;
                skid_valid_next = 1'b0;
            end
        end else if (in_fire) begin
            if (!main_valid_reg || out_fire) begin
                main_next       = in_data;
                main_valid_next = 1'b1;
            end else begin
                skid_next       = in_data;
                skid_valid_next = 1'b1;
            end
        end else if (out_fire) begin
            main_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

endmodule

FILE: rtl/status_led_blink_breathe_controller.sv
// Top level of the status LED blink and breathe controller.
// Each accepted request is one LED update tick carrying the system state, and it yields
// exactly one result holding nine RGB channel levels and an RF switch LED action. A new
// request is taken in every cycle while s_tready is high; its result is computed from the
// core state and registered in the output buffer's main register, or in its skid register.
// A two-entry output buffer keeps requests flowing while one result waits, so s_tready
// drops only when two results are held. The user writes settings over APB only while no
// request is in flight; the block itself does not enforce this.
module status_led_blink_breathe_controller (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // s_tdata: system_state [2:0], zero padding [7:3].
    input  logic [slbb_pkg::S_TDATA_W-1:0] s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // m_tdata: left_red, left_green, left_blue, mid_red, mid_green, mid_blue,
    // right_red, right_green, right_blue (8 bits each), rf_switch_led [73:72], zeros above.
    output logic [slbb_pkg::M_TDATA_W-1:0] m_tdata,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [slbb_pkg::APB_AW-1:0]    paddr,
    input  logic [slbb_pkg::APB_DW-1:0]    pwdata,
    output logic [slbb_pkg::APB_DW-1:0]    prdata,
    output logic                           pready
);
    import slbb_pkg::*;

    cfg_t    cfg;
    result_t result;
    logic    tick;

    assign tick = s_tvalid && s_tready;

    slbb_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    slbb_core u_core (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .tick         (tick),
        .system_state (s_tdata[STATE_W-1:0]),
        .cfg          (cfg),
        .result       (result)
    );

    slbb_out_buf u_out_buf (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_data  (result),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

FILE: rtl/slbb_checker.sv
// Port-level checks for the status LED controller, bound to the top level.
module slbb_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [slbb_pkg::M_TDATA_W-1:0] m_tdata
);
    import slbb_pkg::*;

    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("Result shown right after reset.");

    a_hold_stalled: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("Stalled result changed or vanished.");

    a_rf_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[73:72] != 2'd3 && m_tdata[M_TDATA_W-1:74] == '0)
        else $error("Invalid RF action code or nonzero padding.");

    a_off_dark: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[73:72] == RF_OFF |-> m_tdata[71:0] == '0)
        else $error("LED lit while the RF switch LED is being turned off.");

    a_rf_on_solid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[73:72] == RF_ON |->
            m_tdata[23:0] == '0 && m_tdata[71:48] == '0 && m_tdata[31:24] == '0)
        else $error("RF switch LED turned on with sides lit or red shown.");

endmodule

bind status_led_blink_breathe_controller slbb_checker u_slbb_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
